[rtl/xpr_pkg.sv]
// ----------------------------------------------------------------------------
// xpr_pkg
// Types and constants shared by the XMODEM checksum packet receiver.
// ----------------------------------------------------------------------------
package xpr_pkg;

  localparam int PAYLOAD_BYTES_DEFAULT = 128;

  localparam int TIMEOUT_W   = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [TIMEOUT_W-1:0] START_TIMEOUT_RESET = 16'd1000;
  localparam logic [TIMEOUT_W-1:0] BYTE_TIMEOUT_RESET  = 16'd100;

  localparam logic [CFG_INDEX_W-1:0] CFG_START_TIMEOUT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BYTE_TIMEOUT  = 1'd1;

  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_EOT = 8'h04;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_EOT          = 4'd1;
  localparam logic [3:0] ST_START_ERR    = 4'd2;
  localparam logic [3:0] ST_HDR_TIMEOUT  = 4'd3;
  localparam logic [3:0] ST_WRONG_NUM    = 4'd4;
  localparam logic [3:0] ST_BAD_COMP     = 4'd5;
  localparam logic [3:0] ST_DATA_TIMEOUT = 4'd6;
  localparam logic [3:0] ST_SUM_TIMEOUT  = 4'd7;
  localparam logic [3:0] ST_SUM_MISMATCH = 4'd8;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
    logic [7:0] expected_num;
  } item_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] data_byte;
    logic [6:0] byte_index;
    logic [3:0] status;
    logic       send_ack;
    logic       last_in_packet;
  } result_t;

endpackage

[rtl/xpr_core.sv]
// ----------------------------------------------------------------------------
// xpr_core
// Packet state machine: one state update per accepted word, with the
// timeout registers and tick counter.
// ----------------------------------------------------------------------------
module xpr_core import xpr_pkg::*; #(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  item_t                  item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [TIMEOUT_W-1:0]   cfg_data,
  output logic                   res_valid,
  output result_t                res
);

  localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);

  typedef enum logic [2:0] {
    PH_START,
    PH_NUM,
    PH_COMP,
    PH_DATA,
    PH_SUM
  } phase_t;

  phase_t               phase, phase_next;
  logic [CNT_W-1:0]     data_count, data_count_next;
  logic [7:0]           running_sum, running_sum_next;
  logic [7:0]           received_num, received_num_next;
  logic [TIMEOUT_W-1:0] wait_ticks, wait_ticks_next;
  logic [TIMEOUT_W-1:0] start_timeout, byte_timeout;

  logic [TIMEOUT_W-1:0] wait_inc;
  logic [TIMEOUT_W-1:0] limit;
  logic                 in_packet;
  logic [7:0]           count_ext;
  logic                 fire;
  logic [3:0]           code;
  logic                 ack;

  assign wait_inc  = (wait_ticks == {TIMEOUT_W{1'b1}}) ? wait_ticks
                                                       : wait_ticks + 1'b1;
  assign in_packet = (phase == PH_NUM) || (phase == PH_COMP) ||
                     (phase == PH_DATA) || (phase == PH_SUM);
  assign limit     = in_packet ? byte_timeout : start_timeout;
  assign count_ext = 8'(data_count);

  always_comb begin
    phase_next        = phase;
    data_count_next   = data_count;
    running_sum_next  = running_sum;
    received_num_next = received_num;
    wait_ticks_next   = wait_ticks;
    fire              = 1'b0;
    code              = ST_OK;
    ack               = 1'b0;
    res_valid         = 1'b0;
    res               = '0;

    if (accept) begin
      if (item.req_type == REQ_TICK) begin
        wait_ticks_next = wait_inc;
        if (wait_inc >= limit) begin
          fire = 1'b1;
          case (phase)
            PH_NUM, PH_COMP: code = ST_HDR_TIMEOUT;
            PH_DATA:         code = ST_DATA_TIMEOUT;
            PH_SUM:          code = ST_SUM_TIMEOUT;
            default:         code = ST_START_ERR;
          endcase
        end
      end else begin
        wait_ticks_next = '0;
        case (phase)
          PH_NUM: begin
            received_num_next = item.rx_byte;
            phase_next        = PH_COMP;
          end
          PH_COMP: begin
            if (received_num != item.expected_num) begin
              fire = 1'b1;
              code = ST_WRONG_NUM;
            end else if ((received_num ^ item.rx_byte) != 8'hFF) begin
              fire = 1'b1;
              code = ST_BAD_COMP;
            end else begin
              data_count_next  = '0;
              running_sum_next = '0;
              phase_next       = PH_DATA;
            end
          end
          PH_DATA: begin
            res_valid        = 1'b1;
            res.out_kind     = KIND_DATA;
            res.data_byte    = item.rx_byte;
            res.byte_index   = count_ext[6:0];
            running_sum_next = running_sum + item.rx_byte;
            data_count_next  = data_count + 1'b1;
            // counter restarts at zero each packet, so equality ends it
            if (data_count_next == CNT_W'(PAYLOAD_BYTES)) begin
              phase_next = PH_SUM;
            end
          end
          PH_SUM: begin
            fire = 1'b1;
            code = (item.rx_byte != running_sum) ? ST_SUM_MISMATCH : ST_OK;
          end
          default: begin
            if (item.rx_byte == BYTE_EOT) begin
              fire = 1'b1;
              code = ST_EOT;
              ack  = 1'b1;
            end else if (item.rx_byte != BYTE_SOH) begin
              fire = 1'b1;
              code = ST_START_ERR;
            end else begin
              phase_next = PH_NUM;
            end
          end
        endcase
      end

      if (fire) begin
        res_valid          = 1'b1;
        res.out_kind       = KIND_STATUS;
        res.status         = code;
        res.send_ack       = ack;
        res.last_in_packet = 1'b1;
        phase_next         = PH_START;
        data_count_next    = '0;
        running_sum_next   = '0;
        wait_ticks_next    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      data_count    <= '0;
      running_sum   <= '0;
      received_num  <= '0;
      wait_ticks    <= '0;
      start_timeout <= START_TIMEOUT_RESET;
      byte_timeout  <= BYTE_TIMEOUT_RESET;
    end else begin
      phase        <= phase_next;
      data_count   <= data_count_next;
      running_sum  <= running_sum_next;
      received_num <= received_num_next;
      wait_ticks   <= wait_ticks_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_TIMEOUT: start_timeout <= cfg_data;
          CFG_BYTE_TIMEOUT:  byte_timeout  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // data phase never runs past the payload length
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (data_count < CNT_W'(PAYLOAD_BYTES)))
    else $error("xpr_core: data count past payload length");

  // a status result always leaves the machine waiting for a start byte
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.out_kind == KIND_STATUS) |=> (phase == PH_START))
    else $error("xpr_core: status did not return to start");

  // a tick below the limit leaves the phase alone
  assert property (@(posedge clk) disable iff (rst)
    (accept && item.req_type == REQ_TICK && !res_valid) |=> $stable(phase))
    else $error("xpr_core: tick changed phase without timeout");

endmodule

[rtl/xpr_out_buf.sv]
// ----------------------------------------------------------------------------
// xpr_out_buf
// Two-word result queue: head register drives the output, second word
// catches a result while the head is stalled.
// ----------------------------------------------------------------------------
module xpr_out_buf import xpr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_word,
  output logic    full,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic [1:0] count;
  result_t    head, spare;
  logic       pop;

  assign result_valid = (count != 2'd0);
  assign full         = (count == 2'd2);
  assign pop          = result_valid && !result_stall;
  assign result       = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b11: begin
          if (count == 2'd2) begin
            head  <= spare;
            spare <= push_word;
          end else begin
            head <= push_word;
          end
        end
        2'b01: begin
          head  <= spare;
          count <= count - 2'd1;
        end
        2'b10: begin
          if (count == 2'd0) begin
            head <= push_word;
          end else begin
            spare <= push_word;
          end
          count <= count + 2'd1;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("xpr_out_buf: count overflow");

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("xpr_out_buf: push into full queue");

  assert property (@(posedge clk) disable iff (rst)
    (pop && !push && count == 2'd2) |=> (head == $past(spare)))
    else $error("xpr_out_buf: spare word not advanced");

endmodule

[rtl/xmodem_packet_receiver.sv]
// ----------------------------------------------------------------------------
// xmodem_packet_receiver
// XMODEM checksum-mode packet receiver: bytes and millisecond ticks in,
// payload words and packet status words out.
// ----------------------------------------------------------------------------
// Takes one word per clock (a received byte or a tick) unless stalled. Each
// word is handled in the cycle it is accepted by the packet state machine,
// and any result is registered in the queue head before output. Results
// go through a two-word queue, so the input keeps flowing while downstream
// stalls; the input stalls only once both queue words hold results not yet taken.
// Timeout limits may be rewritten at any time the block is idle.
// ----------------------------------------------------------------------------
module xmodem_packet_receiver import xpr_pkg::*; #(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [TIMEOUT_W-1:0]   cfg_data
);

  logic    accept;
  logic    res_valid;
  result_t res;
  logic    full;

  assign item_stall = full;
  assign accept     = item_valid && !full;

  xpr_core #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  xpr_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (res_valid),
    .push_word    (res),
    .full         (full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
